>>> design/pgva_pkg.sv
// ----------------------------------------------------------------------------
// pgva_pkg
// Types and constants shared by the void area controller and datapath.
// ----------------------------------------------------------------------------
package pgva_pkg;

    localparam int COORD_W = 24;
    localparam int TOTAL_W = 34;
    localparam int AREA_W  = 48;
    localparam int COUNT_W = 21;
    localparam int IDX_W   = 3;

    localparam logic [COORD_W-1:0] ONE_Q16 = 24'h010000;
    localparam logic [COORD_W-1:0] TWO_Q16 = 24'h020000;

    localparam logic [AREA_W-1:0]  POS_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [AREA_W-1:0]  NEG_MIN   = 48'h8000_0000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 21'h1F_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 34'h3_FFFF_FFFF;

    localparam logic [COORD_W-1:0] CUTOFF_RST  = 24'd98304;
    localparam logic [COORD_W-1:0] SPACING_RST = 24'd3277;

    localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_CUTOFF  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPACING = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_WIDTH_Y = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVX_INIT,
        S_DIVX,
        S_DIVY_INIT,
        S_DIVY,
        S_GRID,
        S_PROBE,
        S_DIFF,
        S_SQ,
        S_CMP,
        S_ADV,
        S_M1_MUL,
        S_M1_SUB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic begin_pop;
        logic div_start;
        logic div_sel;
        logic div_step;
        logic grid_init;
        logic mem_rd;
        logic diff;
        logic sq;
        logic next_k;
        logic mark_uncov;
        logic next_probe;
        logic m1_mul;
        logic m1_sub;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic grid_empty;
        logic k_end;
        logic covered;
        logic last_probe;
        logic mode;
    } t_stat;

endpackage

>>> design/pgva_ctrl.sv
// ----------------------------------------------------------------------------
// pgva_ctrl
// Sequencer for loading, grid size division, probe walk and area mode.
// ----------------------------------------------------------------------------
module pgva_ctrl
    import pgva_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_final_cell,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_final_cell) begin
                    n_state = i_stat.mode ? S_M1_MUL : S_DIVX_INIT;
                end
            end
            S_DIVX_INIT: n_state = S_DIVX;
            S_DIVX:      if (i_stat.div_last) n_state = S_DIVY_INIT;
            S_DIVY_INIT: n_state = S_DIVY;
            S_DIVY:      if (i_stat.div_last) n_state = S_GRID;
            S_GRID:      n_state = i_stat.grid_empty ? S_DONE : S_PROBE;
            S_PROBE:     n_state = i_stat.k_end ? S_ADV : S_DIFF;
            S_DIFF:      n_state = S_SQ;
            S_SQ:        n_state = S_CMP;
            S_CMP:       n_state = i_stat.covered ? S_ADV : S_PROBE;
            S_ADV:       n_state = i_stat.last_probe ? S_DONE : S_PROBE;
            S_M1_MUL:    n_state = S_M1_SUB;
            S_M1_SUB:    n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load      = i_start;
                o_cmd.begin_pop = i_start && i_final_cell;
            end
            S_DIVX_INIT: o_cmd.div_start = 1'b1;
            S_DIVX:      o_cmd.div_step = 1'b1;
            S_DIVY_INIT: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
            end
            S_DIVY:      o_cmd.div_step = 1'b1;
            S_GRID:      o_cmd.grid_init = 1'b1;
            S_PROBE: begin
                // With every stored centre checked, the probe is uncovered.
                o_cmd.mark_uncov = i_stat.k_end;
                o_cmd.mem_rd     = !i_stat.k_end;
            end
            S_DIFF:      o_cmd.diff = 1'b1;
            S_SQ:        o_cmd.sq = 1'b1;
            S_CMP:       o_cmd.next_k = !i_stat.covered;
            S_ADV:       o_cmd.next_probe = !i_stat.last_probe;
            S_M1_MUL:    o_cmd.m1_mul = 1'b1;
            S_M1_SUB:    o_cmd.m1_sub = 1'b1;
            S_DONE:      o_cmd.emit = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

endmodule

>>> design/pgva_datapath.sv
// ----------------------------------------------------------------------------
// pgva_datapath
// Configuration, centre memory, divider, probe distance test and area math.
// ----------------------------------------------------------------------------
module pgva_datapath
    import pgva_pkg::*;
#(
    parameter int MAX_CELLS     = 1024,
    parameter int MAX_GRID_SIDE = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data,
    input  logic [COORD_W-1:0] i_centre_x,
    input  logic [COORD_W-1:0] i_centre_y,
    input  logic [COORD_W-1:0] i_cell_area,
    output logic               o_result_valid,
    output logic [AREA_W-1:0]  o_uncov_area,
    output logic [COUNT_W-1:0] o_uncovered_points,
    output logic               o_grid_clipped
);

    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int SW = $clog2(MAX_GRID_SIDE + 1);
    localparam logic [COORD_W-1:0] SIDE_LIM = COORD_W'(MAX_GRID_SIDE);

    // Configuration registers.
    logic               r_mode;
    logic [COORD_W-1:0] r_cutoff;
    logic [COORD_W-1:0] r_spacing;
    logic [COORD_W-1:0] r_width_x;
    logic [COORD_W-1:0] r_width_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_cutoff  <= CUTOFF_RST;
            r_spacing <= SPACING_RST;
            r_width_x <= '0;
            r_width_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:    r_mode    <= i_cfg_data[0];
                REG_CUTOFF:  r_cutoff  <= i_cfg_data;
                REG_SPACING: r_spacing <= i_cfg_data;
                REG_WIDTH_X: r_width_x <= i_cfg_data;
                REG_WIDTH_Y: r_width_y <= i_cfg_data;
                default:     r_mode    <= r_mode;
            endcase
        end
    end

    // Population: centre memory, fill count and area sum.
    logic [COORD_W-1:0] r_mem_x [MAX_CELLS];
    logic [COORD_W-1:0] r_mem_y [MAX_CELLS];
    logic [CW-1:0]      r_loaded;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W:0]   total_sum;
    logic               room;

    assign room      = (r_loaded < CW'(MAX_CELLS));
    assign total_sum = {1'b0, r_total} + {{(TOTAL_W-COORD_W+1){1'b0}}, i_cell_area};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_mem_x[r_loaded[AW-1:0]] <= i_centre_x;
            r_mem_y[r_loaded[AW-1:0]] <= i_centre_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_total  <= '0;
        end else if (i_cmd.emit) begin
            r_loaded <= '0;
            r_total  <= '0;
        end else if (i_cmd.load && room) begin
            r_loaded <= r_loaded + CW'(1);
            r_total  <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        end
    end

    // Grid side: restoring division of (width - 2.0) by the spacing, one bit a cycle.
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_quo;
    logic [4:0]         r_div_cnt;
    logic               r_div_sel;
    logic               r_div_zero;
    logic [COORD_W:0]   trial;
    logic [COORD_W-1:0] n_rem;
    logic [COORD_W-1:0] n_quo;
    logic [COORD_W-1:0] div_width;
    logic [SW-1:0]      r_nx;
    logic [SW-1:0]      r_ny;
    logic [SW-1:0]      side;
    logic               side_clip;
    logic               r_clipped;

    assign div_width = i_cmd.div_sel ? r_width_y : r_width_x;
    assign trial     = {r_rem, r_quo[COORD_W-1]} - {1'b0, r_spacing};

    always_comb begin
        if (!trial[COORD_W]) begin
            n_rem = trial[COORD_W-1:0];
            n_quo = {r_quo[COORD_W-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[COORD_W-2:0], r_quo[COORD_W-1]};
            n_quo = {r_quo[COORD_W-2:0], 1'b0};
        end
        side_clip = 1'b0;
        if (r_div_zero) begin
            side = '0;
        end else if (n_quo > SIDE_LIM) begin
            side      = SW'(MAX_GRID_SIDE);
            side_clip = 1'b1;
        end else begin
            side = n_quo[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem      <= '0;
            r_quo      <= div_width - TWO_Q16;
            r_div_cnt  <= '0;
            r_div_sel  <= i_cmd.div_sel;
            r_div_zero <= (div_width < TWO_Q16) || (r_spacing == '0);
        end else if (i_cmd.div_step) begin
            r_rem     <= n_rem;
            r_quo     <= n_quo;
            r_div_cnt <= r_div_cnt + 5'd1;
            if (o_stat.div_last) begin
                if (r_div_sel) begin
                    r_ny <= side;
                end else begin
                    r_nx <= side;
                end
            end
        end
    end

    // Probe walk and distance test.
    logic [SW-1:0]        r_i;
    logic [SW-1:0]        r_j;
    logic [COORD_W-1:0]   r_px;
    logic [COORD_W-1:0]   r_py;
    logic [CW-1:0]        r_k;
    logic [COORD_W-1:0]   r_rx;
    logic [COORD_W-1:0]   r_ry;
    logic [COORD_W-1:0]   r_dx;
    logic [COORD_W-1:0]   r_dy;
    logic [2*COORD_W-1:0] r_sx;
    logic [2*COORD_W-1:0] r_sy;
    logic [2*COORD_W-1:0] r_reach2;
    logic [2*COORD_W-1:0] r_sep2;
    logic [2*COORD_W:0]   d2;
    logic [2*COORD_W+2:0] d2x4;

    assign d2   = {1'b0, r_sx} + {1'b0, r_sy};
    assign d2x4 = {d2, 2'b00};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rx <= r_mem_x[r_k[AW-1:0]];
            r_ry <= r_mem_y[r_k[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grid_init) begin
            r_i      <= '0;
            r_j      <= '0;
            r_px     <= ONE_Q16;
            r_py     <= ONE_Q16;
            r_k      <= '0;
            r_reach2 <= r_cutoff * r_cutoff;
            r_sep2   <= r_spacing * r_spacing;
        end else if (i_cmd.next_probe) begin
            r_k <= '0;
            if (r_j == r_ny - SW'(1)) begin
                r_j  <= '0;
                r_py <= ONE_Q16;
                r_i  <= r_i + SW'(1);
                r_px <= r_px + r_spacing;
            end else begin
                r_j  <= r_j + SW'(1);
                r_py <= r_py + r_spacing;
            end
        end else if (i_cmd.next_k) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.diff) begin
            r_dx <= (r_rx > r_px) ? r_rx - r_px : r_px - r_rx;
            r_dy <= (r_ry > r_py) ? r_ry - r_py : r_py - r_ry;
        end
        if (i_cmd.sq) begin
            r_sx <= r_dx * r_dx;
            r_sy <= r_dy * r_dy;
        end
    end

    // Result registers.
    logic [AREA_W-1:0]  r_area;
    logic [COUNT_W-1:0] r_count;
    logic [2*COORD_W-1:0] r_mesh;
    logic [AREA_W:0]    acc_sum;
    logic signed [AREA_W+3:0] m1_diff;

    assign acc_sum = {1'b0, r_area} + {1'b0, r_sep2};
    assign m1_diff = $signed({4'b0, r_mesh}) - $signed({2'b0, r_total, 16'b0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_pop) begin
            r_area    <= '0;
            r_count   <= '0;
            r_clipped <= 1'b0;
        end else begin
            if (i_cmd.div_step && o_stat.div_last && side_clip) begin
                r_clipped <= 1'b1;
            end
            if (i_cmd.mark_uncov) begin
                r_count <= (r_count == COUNT_MAX) ? COUNT_MAX : r_count + COUNT_W'(1);
                // Adding one spacing squared per point saturates exactly like the
                // full product would.
                r_area  <= (acc_sum > {1'b0, POS_MAX}) ? POS_MAX : acc_sum[AREA_W-1:0];
            end
            if (i_cmd.m1_sub) begin
                if (m1_diff > $signed({4'b0, POS_MAX})) begin
                    r_area <= POS_MAX;
                end else if (m1_diff < $signed({4'hF, NEG_MIN})) begin
                    r_area <= NEG_MIN;
                end else begin
                    r_area <= m1_diff[AREA_W-1:0];
                end
            end
        end
        if (i_cmd.m1_mul) begin
            r_mesh <= r_width_x * r_width_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
        end
    end

    assign o_uncov_area       = r_area;
    assign o_uncovered_points = r_count;
    assign o_grid_clipped     = r_clipped;

    assign o_stat.div_last   = (r_div_cnt == 5'(COORD_W - 1));
    assign o_stat.grid_empty = (r_nx == '0) || (r_ny == '0);
    assign o_stat.k_end      = (r_k == r_loaded);
    assign o_stat.covered    = (d2x4 < {3'b000, r_reach2});
    assign o_stat.last_probe = (r_i == r_nx - SW'(1)) && (r_j == r_ny - SW'(1));
    assign o_stat.mode       = r_mode;

endmodule

>>> design/pixel_grid_void_area_core.sv
// ----------------------------------------------------------------------------
// pixel_grid_void_area_core
// Void area of a 2-D cell population, by probe grid or by area difference.
// ----------------------------------------------------------------------------
// Usage: each item is one cell, accepted at a clock edge with start high and
// busy low. Non-final items are loaded each in turn and busy stays low, so a
// population streams in at one item per cycle. The item with final_cell set
// is loaded too and starts the evaluation; busy is high until it ends.
// In area mode the result follows the mesh area product and the subtraction of
// the summed cell areas. In centre mode the two grid sides are found by a
// one-bit-a-cycle divider, then each probe point reads stored centres one at a
// time from the centre memory, each one differenced, squared and compared,
// stopping at the first covering centre; a point with none is uncovered.
// The result is shown for one cycle with o_result_valid; the receiver cannot
// stall it. The population is emptied when the result is issued.
// Reset restores the register defaults and empties the population; the
// centre memory is not cleared, as only entries loaded since are read.
// Configuration writes are taken at once; the user keeps them to idle time.
// ----------------------------------------------------------------------------
module pixel_grid_void_area_core
    import pgva_pkg::*;
#(
    parameter int MAX_CELLS     = 1024,
    parameter int MAX_GRID_SIDE = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] i_centre_x,
    input  logic [COORD_W-1:0] i_centre_y,
    input  logic [COORD_W-1:0] i_cell_area,
    input  logic               i_final_cell,
    output logic               o_result_valid,
    output logic [AREA_W-1:0]  o_uncov_area,
    output logic [COUNT_W-1:0] o_uncovered_points,
    output logic               o_grid_clipped
);

    t_cmd  cmd;
    t_stat stat;

    pgva_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_final_cell (i_final_cell),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    pgva_datapath #(
        .MAX_CELLS     (MAX_CELLS),
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_centre_x         (i_centre_x),
        .i_centre_y         (i_centre_y),
        .i_cell_area        (i_cell_area),
        .o_result_valid     (o_result_valid),
        .o_uncov_area       (o_uncov_area),
        .o_uncovered_points (o_uncovered_points),
        .o_grid_clipped     (o_grid_clipped)
    );

`ifndef SYNTH
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result issued while evaluation still running");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe lasted more than one cycle");

    a_plain_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_final_cell) |=> (!busy && !o_result_valid))
        else $error("non-final item started an evaluation");

    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_final_cell) |=> busy)
        else $error("final item did not start an evaluation");
`endif

endmodule
